// File: hdl/multi_pattern_string_matcher_defines.svh
// Assertion macros for the multi-pattern string matcher.
`ifndef MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define MPSM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MPSM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MPSM_ASSERT_ALWAYS(label, expr, msg)
`define MPSM_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

// File: hdl/mpsm_pkg.sv
// Shared types and constants of the multi-pattern string matcher.
package mpsm_pkg;

    localparam int NODES_DEF = 1024;
    localparam int ALPHABET_DEF = 256;
    localparam longint unsigned TEXT_MAX_DEF = 64'd65535;

    localparam int SYM_W = 8;
    localparam int OFFSET_W = 16;
    localparam int LENGTH_W = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int REG_MATCH_AT_END = 0;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0,
        STAT_BAD_SYMBOL = 2'd1,
        STAT_TABLE_FULL = 2'd2
    } status_t;

    // pending work on the walk stack
    typedef enum logic [1:0] {
        FR_GO_STORE = 2'd0,
        FR_LINK_CONT = 2'd1,
        FR_LINK_STORE = 2'd2,
        FR_GO_CONT = 2'd3
    } frame_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_CHK,
        ST_LD_END,
        ST_GO_RD,
        ST_GO_CHK,
        ST_LINK_RD,
        ST_LINK_CHK,
        ST_RET,
        ST_POP_CHK,
        ST_SC_RD,
        ST_SC_CHK,
        ST_OUT
    } state_t;

endpackage

// File: hdl/mpsm_intf.sv
// Valid/ready channel interfaces for input bytes and results.
interface mpsm_item_if import mpsm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, mode, symbol, last, input ready);
    modport sink (input valid, mode, symbol, last, output ready);
endinterface

interface mpsm_result_if import mpsm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                matched;
    logic [OFFSET_W-1:0] match_offset;
    logic [LENGTH_W-1:0] match_length;
    logic                done_res;

    modport source (output valid, status, matched, match_offset, match_length, done_res,
                    input ready);
    modport sink (input valid, status, matched, match_offset, match_length, done_res,
                  output ready);
endinterface

// File: hdl/mpsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpsm_ram import mpsm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/multi_pattern_string_matcher.sv
// Multi-pattern string matcher: a trie with lazily filled goto and fail links.
// Pattern bytes (mode 0) build the trie; text bytes (mode 1) walk it and the
// result of the text's last byte reports the first pattern end found (with
// match-at-end set, only one at the last byte). After reset the block sweeps
// its tables and takes no byte meanwhile; configuration writes are taken as ever.
// One byte at a time: a pattern byte skips the transition lookup once the
// pattern has failed, and a text byte whose goto transition is already in the
// table needs no walk. An unknown transition walks fail links through the
// transition and fail memories with an explicit stack in RAM, each link taking
// longer when it must be worked out first; the single-port reads of these
// memories set the pace. The result register frees the next byte while a
// result waits.
`include "multi_pattern_string_matcher_defines.svh"

module multi_pattern_string_matcher import mpsm_pkg::*; #(
    parameter int              NODES = NODES_DEF,
    parameter int              ALPHABET = ALPHABET_DEF,
    parameter longint unsigned TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mpsm_item_if.sink             item,
    mpsm_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NW = $clog2(NODES);
    localparam int TAW = NW + SYM_W;
    localparam int TDEPTH = NODES << SYM_W;
    localparam int SDEPTH = 2 * NODES;
    localparam int SAW = $clog2(SDEPTH);
    localparam int SPW = SAW + 1;
    localparam int PW = $clog2(TEXT_MAX + 64'd1);
    localparam int CW = (PW > NW) ? PW : NW;
    localparam int NDW = 2 * NW + SYM_W;
    localparam int SFW = 2 + NW + SYM_W;

    // configuration
    logic cfg_end_reg;
    logic cfg_hit;

    assign pready = 1'b1;
    assign cfg_hit = (paddr[2] == 1'(REG_MATCH_AT_END));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_end_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            cfg_end_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(CFG_DATA_W-1){1'b0}}, cfg_end_reg} : '0;

    // memories
    logic           t_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [NW:0]    t_wdata, t_rdata;
    logic           f_we;
    logic [NW-1:0]  f_waddr, f_raddr;
    logic [NW:0]    f_wdata, f_rdata;
    logic           n_we;
    logic [NW-1:0]  n_waddr, n_raddr;
    logic [NDW-1:0] n_wdata, n_rdata;
    logic           e_we;
    logic [NW-1:0]  e_waddr, e_raddr;
    logic           e_wdata, e_rdata;
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [SFW-1:0] s_wdata, s_rdata;

    mpsm_ram #(.WIDTH(NW + 1), .DEPTH(TDEPTH)) u_trans_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    mpsm_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_fail_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    mpsm_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    mpsm_ram #(.WIDTH(1), .DEPTH(NODES)) u_end_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    mpsm_ram #(.WIDTH(SFW), .DEPTH(SDEPTH)) u_stack_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    // node record: parent, symbol from parent, depth
    logic [NW-1:0]    n_parent, n_depth;
    logic [SYM_W-1:0] n_psym;
    frame_t           e_kind;
    logic [NW-1:0]    e_node;
    logic [SYM_W-1:0] e_sym;

    assign n_parent = n_rdata[NDW-1 -: NW];
    assign n_psym = n_rdata[NW +: SYM_W];
    assign n_depth = n_rdata[NW-1:0];
    assign e_kind = frame_t'(s_rdata[SFW-1 -: 2]);
    assign e_node = s_rdata[SYM_W +: NW];
    assign e_sym = s_rdata[SYM_W-1:0];

    // control state
    state_t              state_reg, state_next;
    logic [TAW-1:0]      clr_reg, clr_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_reg, last_next;
    logic [NW-1:0]       load_node_reg, load_node_next;
    status_t             load_err_reg, load_err_next;
    logic [NW-1:0]       nodes_used_reg, nodes_used_next;
    logic [NW-1:0]       scan_node_reg, scan_node_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                found_reg, found_next;
    logic [NW-1:0]       v_reg, v_next;
    logic [SYM_W-1:0]    c_reg, c_next;
    logic [NW-1:0]       r_reg, r_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [SPW-1:0]      sp_dec;
    status_t             res_status_reg, res_status_next;
    logic                res_matched_reg, res_matched_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [LENGTH_W-1:0] res_length_reg, res_length_next;
    logic                res_done_reg, res_done_next;
    logic                out_load;
    logic                item_acc;
    logic                sym_bad;
    logic [CW-1:0]       pos_c, dep_c;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc = item.valid && item.ready;
    assign sym_bad = ({1'b0, item.symbol} >= (SYM_W + 1)'(ALPHABET));
    assign sp_dec = sp_reg - 1'b1;
    assign pos_c = CW'(pos_reg);
    assign dep_c = CW'(n_depth);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            load_node_reg <= '0;
            load_err_reg <= STAT_OK;
            nodes_used_reg <= NW'(1);
            scan_node_reg <= '0;
            pos_reg <= '0;
            found_reg <= 1'b0;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            load_node_reg <= load_node_next;
            load_err_reg <= load_err_next;
            nodes_used_reg <= nodes_used_next;
            scan_node_reg <= scan_node_next;
            pos_reg <= pos_next;
            found_reg <= found_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        last_reg <= last_next;
        v_reg <= v_next;
        c_reg <= c_next;
        r_reg <= r_next;
        res_status_reg <= res_status_next;
        res_matched_reg <= res_matched_next;
        res_offset_reg <= res_offset_next;
        res_length_reg <= res_length_next;
        res_done_reg <= res_done_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        sym_next = sym_reg;
        last_next = last_reg;
        load_node_next = load_node_reg;
        load_err_next = load_err_reg;
        nodes_used_next = nodes_used_reg;
        scan_node_next = scan_node_reg;
        pos_next = pos_reg;
        found_next = found_reg;
        v_next = v_reg;
        c_next = c_reg;
        r_next = r_reg;
        sp_next = sp_reg;
        res_status_next = res_status_reg;
        res_matched_next = res_matched_reg;
        res_offset_next = res_offset_reg;
        res_length_next = res_length_reg;
        res_done_next = res_done_reg;
        out_load = 1'b0;

        t_we = 1'b0;
        t_waddr = {v_reg, c_reg};
        t_wdata = '0;
        t_raddr = {v_reg, c_reg};
        f_we = 1'b0;
        f_waddr = v_reg;
        f_wdata = '0;
        f_raddr = v_reg;
        n_we = 1'b0;
        n_waddr = nodes_used_reg;
        n_wdata = '0;
        n_raddr = v_reg;
        e_we = 1'b0;
        e_waddr = load_node_reg;
        e_wdata = 1'b0;
        e_raddr = scan_node_reg;
        s_we = 1'b0;
        s_waddr = sp_reg[SAW-1:0];
        s_wdata = '0;
        s_raddr = sp_dec[SAW-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                // node-indexed tables wrap and are cleared many times over
                t_we = 1'b1;
                t_waddr = clr_reg;
                f_we = 1'b1;
                f_waddr = clr_reg[NW-1:0];
                n_we = 1'b1;
                n_waddr = clr_reg[NW-1:0];
                e_we = 1'b1;
                e_waddr = clr_reg[NW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item_acc)
                begin
                    sym_next = item.symbol;
                    last_next = item.last;
                    res_status_next = STAT_OK;
                    res_matched_next = 1'b0;
                    res_offset_next = '0;
                    res_length_next = '0;
                    res_done_next = item.last;
                    if (item.mode == MODE_PATTERN)
                    begin
                        if (load_err_reg != STAT_OK)
                        begin
                            state_next = ST_LD_END;
                        end
                        else if (sym_bad)
                        begin
                            load_err_next = STAT_BAD_SYMBOL;
                            state_next = ST_LD_END;
                        end
                        else
                        begin
                            t_raddr = {load_node_reg, item.symbol};
                            n_raddr = load_node_reg;
                            state_next = ST_LD_CHK;
                        end
                    end
                    else if (found_reg)
                    begin
                        state_next = item.last ? ST_SC_RD : ST_OUT;
                    end
                    else
                    begin
                        if (pos_reg < PW'(TEXT_MAX))
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        if (sym_bad)
                        begin
                            scan_node_next = '0;
                            state_next = ST_SC_RD;
                        end
                        else
                        begin
                            v_next = scan_node_reg;
                            c_next = item.symbol;
                            state_next = ST_GO_RD;
                        end
                    end
                end
            end

            ST_LD_CHK:
            begin
                if (!t_rdata[NW])
                begin
                    if (nodes_used_reg >= NW'(NODES - 1))
                    begin
                        load_err_next = STAT_TABLE_FULL;
                    end
                    else
                    begin
                        t_we = 1'b1;
                        t_waddr = {load_node_reg, sym_reg};
                        t_wdata = {1'b1, nodes_used_reg};
                        n_we = 1'b1;
                        n_waddr = nodes_used_reg;
                        n_wdata = {load_node_reg, sym_reg, n_depth + 1'b1};
                        nodes_used_next = nodes_used_reg + 1'b1;
                        load_node_next = nodes_used_reg;
                    end
                end
                else
                begin
                    load_node_next = t_rdata[NW-1:0];
                end
                state_next = ST_LD_END;
            end

            ST_LD_END:
            begin
                if (last_reg)
                begin
                    res_status_next = load_err_reg;
                    if (load_err_reg == STAT_OK && load_node_reg != '0)
                    begin
                        e_we = 1'b1;
                        e_waddr = load_node_reg;
                        e_wdata = 1'b1;
                    end
                    load_node_next = '0;
                    load_err_next = STAT_OK;
                end
                state_next = ST_OUT;
            end

            ST_GO_RD:
            begin
                state_next = ST_GO_CHK;
            end

            ST_GO_CHK:
            begin
                if (t_rdata[NW])
                begin
                    r_next = t_rdata[NW-1:0];
                    state_next = ST_RET;
                end
                else if (v_reg == '0)
                begin
                    t_we = 1'b1;
                    t_wdata = {1'b1, {NW{1'b0}}};
                    r_next = '0;
                    state_next = ST_RET;
                end
                else
                begin
                    s_we = 1'b1;
                    s_wdata = {FR_GO_CONT, v_reg, c_reg};
                    sp_next = sp_reg + 1'b1;
                    state_next = ST_LINK_RD;
                end
            end

            ST_LINK_RD:
            begin
                state_next = ST_LINK_CHK;
            end

            ST_LINK_CHK:
            begin
                if (f_rdata[NW])
                begin
                    r_next = f_rdata[NW-1:0];
                    state_next = ST_RET;
                end
                else if (v_reg == '0 || n_parent == '0)
                begin
                    f_we = 1'b1;
                    f_wdata = {1'b1, {NW{1'b0}}};
                    r_next = '0;
                    state_next = ST_RET;
                end
                else
                begin
                    s_we = 1'b1;
                    s_wdata = {FR_LINK_CONT, v_reg, n_psym};
                    sp_next = sp_reg + 1'b1;
                    v_next = n_parent;
                    state_next = ST_LINK_RD;
                end
            end

            ST_RET:
            begin
                if (sp_reg == '0)
                begin
                    scan_node_next = r_reg;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    state_next = ST_POP_CHK;
                end
            end

            ST_POP_CHK:
            begin
                case (e_kind)
                    FR_GO_STORE:
                    begin
                        t_we = 1'b1;
                        t_waddr = {e_node, e_sym};
                        t_wdata = {1'b1, r_reg};
                        sp_next = sp_dec;
                        state_next = ST_RET;
                    end
                    FR_GO_CONT:
                    begin
                        // node's link known: step it by the pending symbol
                        s_we = 1'b1;
                        s_waddr = sp_dec[SAW-1:0];
                        s_wdata = {FR_GO_STORE, e_node, e_sym};
                        v_next = r_reg;
                        c_next = e_sym;
                        state_next = ST_GO_RD;
                    end
                    FR_LINK_CONT:
                    begin
                        // parent's link known: now step it by our symbol
                        s_we = 1'b1;
                        s_waddr = sp_dec[SAW-1:0];
                        s_wdata = {FR_LINK_STORE, e_node, e_sym};
                        v_next = r_reg;
                        c_next = e_sym;
                        state_next = ST_GO_RD;
                    end
                    FR_LINK_STORE:
                    begin
                        f_we = 1'b1;
                        f_waddr = e_node;
                        f_wdata = {1'b1, r_reg};
                        sp_next = sp_dec;
                        state_next = ST_RET;
                    end
                    default:
                    begin
                        sp_next = sp_dec;
                        state_next = ST_RET;
                    end
                endcase
            end

            ST_SC_RD:
            begin
                n_raddr = scan_node_reg;
                state_next = ST_SC_CHK;
            end

            ST_SC_CHK:
            begin
                if (e_rdata && (!cfg_end_reg || last_reg))
                begin
                    found_next = 1'b1;
                end
                if (last_reg)
                begin
                    if (e_rdata && pos_c >= dep_c)
                    begin
                        res_matched_next = 1'b1;
                        res_offset_next = OFFSET_W'(pos_c - dep_c);
                        res_length_next = LENGTH_W'(n_depth);
                    end
                    scan_node_next = '0;
                    pos_next = '0;
                    found_next = 1'b0;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!result.valid || result.ready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_matched_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    logic                out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_matched_reg <= res_matched_reg;
            out_offset_reg <= res_offset_reg;
            out_length_reg <= res_length_reg;
            out_done_reg <= res_done_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.matched = out_matched_reg;
    assign result.match_offset = out_offset_reg;
    assign result.match_length = out_length_reg;
    assign result.done_res = out_done_reg;

    `MPSM_ASSERT_IMPLY(a_clear_blocks_input, state_reg == ST_CLEAR, !item.ready, "byte taken during table sweep")
    `MPSM_ASSERT_IMPLY(a_stack_empty_idle, state_reg == ST_IDLE, sp_reg == '0, "walk stack not empty at idle")
    `MPSM_ASSERT_ALWAYS(a_nodes_bound, nodes_used_reg <= NW'(NODES - 1), "node count beyond table")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the multi-pattern string matcher.
module testbench;
    import mpsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CNT = NODES_DEF;
    localparam int SYM_CNT = ALPHABET_DEF;
    localparam int TXT_SAT = 65535;
    localparam int STALL_LIMIT = 1500000;  // covers the table sweep after reset
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        status_t       status;
        logic          matched;
        logic [15:0]   offset;
        logic [9:0]    length;
        logic          done;
    } match_res_t;

    typedef struct {
        logic          mode;
        logic [7:0]    symbol;
        logic          last;
        bit            typed;
        match_res_t    res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    mpsm_item_if item_ch ();
    mpsm_result_if res_ch ();

    multi_pattern_string_matcher dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(res_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    // trie shadow: -1 marks a transition or fail link not yet worked out
    int goto_tab [NODE_CNT*SYM_CNT];
    int fail_tab [NODE_CNT];
    int up_node [NODE_CNT];
    int up_sym [NODE_CNT];
    int node_dep [NODE_CNT];
    bit is_end [NODE_CNT];
    int node_cnt;
    int ld_node;
    int ld_err;
    int sc_node;
    int sc_pos;
    bit sc_hit;
    bit end_only;

    match_res_t pending_q[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int matches_seen = 0;
    int full_seen = 0;
    bit calm = 1'b0;
    bit hold_kick = 1'b0;
    int hold_left = 0;
    int quiet = 0;

    function automatic int trie_next(int v, int c);
        int r;
        if (goto_tab[v*SYM_CNT+c] < 0)
        begin
            r = (v == 0) ? 0 : trie_next(trie_fail(v), c);
            goto_tab[v*SYM_CNT+c] = r;
        end
        return goto_tab[v*SYM_CNT+c];
    endfunction

    function automatic int trie_fail(int v);
        int r;
        if (fail_tab[v] < 0)
        begin
            if (v == 0 || up_node[v] == 0)
                r = 0;
            else
                r = trie_next(trie_fail(up_node[v]), up_sym[v]);
            fail_tab[v] = r;
        end
        return fail_tab[v];
    endfunction

    function automatic match_res_t match_step(logic mode, logic [7:0] sym, logic last);
        match_res_t r;
        int slot;
        r = '{STAT_OK, 1'b0, 16'd0, 10'd0, last};
        if (mode == MODE_PATTERN)
        begin
            if (ld_err == 0)
            begin
                slot = ld_node*SYM_CNT + sym;
                if (goto_tab[slot] < 0)
                begin
                    if (node_cnt >= NODE_CNT-1)
                        ld_err = 2;
                    else
                    begin
                        for (int k = 0; k < SYM_CNT; k++)
                            goto_tab[node_cnt*SYM_CNT+k] = -1;
                        fail_tab[node_cnt] = -1;
                        up_node[node_cnt] = ld_node;
                        up_sym[node_cnt] = sym;
                        node_dep[node_cnt] = node_dep[ld_node] + 1;
                        is_end[node_cnt] = 1'b0;
                        goto_tab[slot] = node_cnt;
                        node_cnt++;
                    end
                end
                if (ld_err == 0)
                    ld_node = goto_tab[slot];
            end
            if (last)
            begin
                r.status = status_t'(ld_err);
                if (ld_err == 0 && ld_node != 0)
                    is_end[ld_node] = 1'b1;
                ld_node = 0;
                ld_err = 0;
            end
        end
        else
        begin
            if (!sc_hit)
            begin
                sc_node = trie_next(sc_node, sym);
                if (sc_pos < TXT_SAT)
                    sc_pos++;
                if (is_end[sc_node] && (!end_only || last))
                    sc_hit = 1'b1;
            end
            if (last)
            begin
                if (is_end[sc_node] && sc_pos >= node_dep[sc_node])
                begin
                    r.matched = 1'b1;
                    r.offset = 16'(sc_pos - node_dep[sc_node]);
                    r.length = 10'(node_dep[sc_node]);
                end
                sc_node = 0;
                sc_pos = 0;
                sc_hit = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic send_beat(logic mode, logic [7:0] sym, logic last, bit typed = 0,
                             match_res_t typed_res = '0);
        match_res_t r;
        if (!calm && $urandom_range(99) < 8)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 30);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode <= mode;
        item_ch.symbol <= sym;
        item_ch.last <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        r = match_step(mode, sym, last);
        if (r.status == STAT_TABLE_FULL)
            full_seen++;
        pending_q.push_back(typed ? typed_res : r);
        beats_in++;
    endtask

    function automatic logic [7:0] pick_sym(bit narrow);
        if (narrow && $urandom_range(9) != 0)
            return 8'h61 + 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    task automatic send_string(logic mode, int len, bit narrow);
        for (int i = 0; i < len; i++)
            send_beat(mode, pick_sym(narrow), i == len-1);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(int idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4*idx);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_MATCH_AT_END)
            end_only = data[0];
        // read back: psel stays high, this cycle is the read setup
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== data[0])
        begin
            $error("match_at_end_only readback: expected %0d, got %0d", data[0], prdata[0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: checker, random stalls, one long hold-off
    initial
    begin
        match_res_t want;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                beats_out++;
                if (pending_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        errors++;
                    end
                    if (res_ch.matched !== want.matched)
                    begin
                        $error("matched: expected %0d, got %0d", want.matched, res_ch.matched);
                        errors++;
                    end
                    if (res_ch.match_offset !== want.offset)
                    begin
                        $error("match_offset: expected %0d, got %0d", want.offset,
                               res_ch.match_offset);
                        errors++;
                    end
                    if (res_ch.match_length !== want.length)
                    begin
                        $error("match_length: expected %0d, got %0d", want.length,
                               res_ch.match_length);
                        errors++;
                    end
                    if (res_ch.done_res !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, res_ch.done_res);
                        errors++;
                    end
                    if (want.matched)
                        matches_seen++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_kick)
            begin
                hold_kick = 1'b0;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= calm || $urandom_range(99) >= 8;
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    stim_row_t rows[] = '{
        '{MODE_PATTERN, 8'h61, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_PATTERN, 8'h62, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_PATTERN, 8'h00, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_PATTERN, 8'hFF, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_PATTERN, 8'h78, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_TEXT,    8'h7A, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_TEXT,    8'h61, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_TEXT,    8'h62, 1'b1, 1'b1, '{STAT_OK, 1'b1, 16'd1, 10'd2, 1'b1}},
        '{MODE_TEXT,    8'h00, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_TEXT,    8'hFF, 1'b1, 1'b1, '{STAT_OK, 1'b1, 16'd0, 10'd2, 1'b1}},
        // bytes after a match are ignored
        '{MODE_TEXT,    8'h78, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_TEXT,    8'h61, 1'b0, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b0}},
        '{MODE_TEXT,    8'h62, 1'b1, 1'b1, '{STAT_OK, 1'b1, 16'd0, 10'd1, 1'b1}},
        // lazy walk leaves root->'q' known, so pattern "q" ends at root
        '{MODE_TEXT,    8'h71, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_PATTERN, 8'h71, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_TEXT,    8'h71, 1'b1, 1'b1, '{STAT_OK, 1'b0, 16'd0, 10'd0, 1'b1}},
        '{MODE_TEXT,    8'h63, 1'b0, 1'b0, '0},
        '{MODE_TEXT,    8'h61, 1'b0, 1'b0, '0},
        '{MODE_TEXT,    8'h61, 1'b0, 1'b0, '0},
        '{MODE_TEXT,    8'h62, 1'b1, 1'b0, '0}
    };

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_PATTERN;
        item_ch.symbol = '0;
        item_ch.last = 1'b0;
        for (int i = 0; i < NODE_CNT*SYM_CNT; i++)
            goto_tab[i] = -1;
        for (int i = 0; i < NODE_CNT; i++)
        begin
            fail_tab[i] = -1;
            up_node[i] = 0;
            up_sym[i] = 0;
            node_dep[i] = 0;
            is_end[i] = 1'b0;
        end
        node_cnt = 1;
        ld_node = 0;
        ld_err = 0;
        sc_node = 0;
        sc_pos = 0;
        sc_hit = 1'b0;
        end_only = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        reg_write(REG_MATCH_AT_END, 0);

        foreach (rows[i])
            send_beat(rows[i].mode, rows[i].symbol, rows[i].last, rows[i].typed, rows[i].res);
        drain();

        // small-alphabet patterns, then texts with a pattern slipped in now and then
        for (int i = 0; i < 40; i++)
            send_string(MODE_PATTERN, $urandom_range(5, 1), 1);
        for (int i = 0; i < 30; i++)
        begin
            if (i == 20)
                hold_kick = 1'b1;
            if ($urandom_range(7) == 0)
                send_string(MODE_PATTERN, $urandom_range(4, 1), 1);
            send_string(MODE_TEXT, $urandom_range(12, 1), 1);
        end
        drain();

        calm = 1'b1;
        reg_write(REG_MATCH_AT_END, 1);
        for (int i = 0; i < 30; i++)
            send_string(MODE_TEXT, $urandom_range(10, 1), 1);
        drain();
        calm = 1'b0;
        reg_write(REG_MATCH_AT_END, 0);

        // fill the node table with long random patterns until it overflows
        while (full_seen < 3)
            send_string(MODE_PATTERN, $urandom_range(60, 20), 0);
        for (int i = 0; i < 25; i++)
            send_string(MODE_TEXT, $urandom_range(12, 1), $urandom_range(1));
        drain();
        reg_write(REG_MATCH_AT_END, 1);
        for (int i = 0; i < 15; i++)
            send_string(MODE_TEXT, $urandom_range(10, 1), 1);
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d input beats, %0d results, %0d matches, %0d table-full errors",
                 beats_in, beats_out, matches_seen, full_seen);
        $display("trie held %0d nodes; both match_at_end_only settings exercised", node_cnt);
        if (errors == 0 && pending_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
